/* sv/sbt_pkg.sv */
// shared types and constants for the static b-tree lower bound search
`default_nettype none

package sbt_pkg;

  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 10;
  localparam int NCNT_W  = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // opcodes of an input item
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_MAX_KEY    = 1'b1;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd1;
  localparam logic [KEY_W-1:0]  MAX_KEY_RST    = 32'd0;

  typedef struct packed {
    logic accept;   // latch the item fields
    logic ld_div;   // slot to row estimate
    logic ld_wr;    // correct estimate and write the key word
    logic q_read;   // read the node row
    logic q_cmp;    // compare the row against the search value
    logic q_next;   // step to the child node
    logic emit;     // present the result
  } cmd_t;

  typedef struct packed {
    logic walk_ok;  // value is in range and at least one node
    logic more;     // child node is still inside the tree
  } sts_t;

endpackage

`default_nettype wire

/* sv/sbt_ctrl.sv */
// control state machine: sequences loads and the level-by-level tree walk
`default_nettype none

module sbt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_opcode,
  output logic               busy,
  output sbt_pkg::cmd_t      cmd,
  input  wire sbt_pkg::sts_t sts
);
  import sbt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LD_DIV = 3'd1;
  localparam logic [2:0] S_LD_WR  = 3'd2;
  localparam logic [2:0] S_Q_CHK  = 3'd3;
  localparam logic [2:0] S_Q_RD   = 3'd4;
  localparam logic [2:0] S_Q_CMP  = 3'd5;
  localparam logic [2:0] S_Q_NXT  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_opcode == OP_LOAD) ? S_LD_DIV : S_Q_CHK;
        end
      end
      S_LD_DIV: begin
        cmd.ld_div = 1'b1;
        state_nxt  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_Q_CHK: begin
        if (sts.walk_ok) begin
          state_nxt = S_Q_RD;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_Q_RD: begin
        cmd.q_read = 1'b1;
        state_nxt  = S_Q_CMP;
      end
      S_Q_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = S_Q_NXT;
      end
      S_Q_NXT: begin
        cmd.q_next = 1'b1;
        if (sts.more) begin
          state_nxt = S_Q_RD;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* sv/sbt_dp.sv */
// datapath: key memory of node rows, slot split, node compare and child step
`default_nettype none

module sbt_dp #(
  parameter int KEYS_PER_NODE = 16,
  parameter int MAX_NODES     = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sbt_pkg::cmd_t                 cmd,
  output sbt_pkg::sts_t                      sts,
  input  wire logic [sbt_pkg::SLOT_W-1:0]    in_load_slot,
  input  wire logic signed [sbt_pkg::KEY_W-1:0] in_load_key,
  input  wire logic signed [sbt_pkg::KEY_W-1:0] in_search_value,
  input  wire logic [sbt_pkg::NCNT_W-1:0]    node_count,
  input  wire logic signed [sbt_pkg::KEY_W-1:0] max_key,
  output logic                               out_valid,
  output logic                               out_found,
  output logic signed [sbt_pkg::KEY_W-1:0]   out_bound_key
);
  import sbt_pkg::*;

  localparam int SLOT_COUNT = KEYS_PER_NODE * MAX_NODES;
  localparam int ROW_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int KI_W       = $clog2(KEYS_PER_NODE);
  localparam int POS_W      = $clog2(KEYS_PER_NODE + 1);
  localparam int CHILD_W    = $clog2(MAX_NODES * (KEYS_PER_NODE + 1) + 1);
  localparam int RECIP_SH   = 16;
  localparam int RECIP_W    = 16;
  localparam int PROD_W     = SLOT_W + RECIP_W;
  localparam int QK_W       = SLOT_W + POS_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / KEYS_PER_NODE);

  logic [KEYS_PER_NODE-1:0][KEY_W-1:0] mem [MAX_NODES];

  logic [SLOT_W-1:0]                   slot_r;
  logic [KEY_W-1:0]                    key_r;
  logic signed [KEY_W-1:0]             search_r;
  logic [SLOT_W-1:0]                   q_est_r;
  logic [SLOT_W-1:0]                   q_est_nxt;
  logic [KEYS_PER_NODE-1:0][KEY_W-1:0] row_r;
  logic [CHILD_W-1:0]                  node_r;
  logic [POS_W-1:0]                    pos_r;
  logic [KEY_W-1:0]                    result_r;
  logic                                out_valid_r;
  logic                                out_found_r;
  logic [KEY_W-1:0]                    out_key_r;

  logic [PROD_W-1:0]        prod;
  logic [QK_W-1:0]          qk_full;
  logic [SLOT_W-1:0]        rem;
  logic                     rem_over;
  logic [SLOT_W-1:0]        q_fix;
  logic [SLOT_W-1:0]        pos_sel;
  logic [ROW_W+SLOT_W-1:0]  row_ext;
  logic                     slot_ok;
  logic [KEYS_PER_NODE-1:0] ge;
  logic [POS_W-1:0]         pos_c;
  logic                     found_c;
  logic [CHILD_W-1:0]       child_c;

  // slot to row: reciprocal estimate is the quotient or one below it
  assign prod      = PROD_W'(slot_r) * PROD_W'(RECIP);
  assign q_est_nxt = prod[PROD_W-1:RECIP_SH];
  assign qk_full   = QK_W'(q_est_r) * QK_W'(KEYS_PER_NODE);
  assign rem       = slot_r - qk_full[SLOT_W-1:0];
  assign rem_over  = (rem >= SLOT_W'(KEYS_PER_NODE));
  assign q_fix     = rem_over ? (q_est_r + SLOT_W'(1)) : q_est_r;
  assign pos_sel   = rem_over ? (rem - SLOT_W'(KEYS_PER_NODE)) : rem;
  assign row_ext   = (ROW_W+SLOT_W)'(q_fix);
  assign slot_ok   = (32'(slot_r) < 32'(SLOT_COUNT));

  // first key not below the search value
  always_comb begin
    pos_c = POS_W'(KEYS_PER_NODE);
    for (int i = 0; i < KEYS_PER_NODE; i++) begin
      ge[i] = ($signed(row_r[i]) >= search_r);
    end
    for (int i = KEYS_PER_NODE - 1; i >= 0; i--) begin
      if (ge[i]) begin
        pos_c = POS_W'(i);
      end
    end
  end

  assign found_c = !($signed(max_key) < search_r);
  assign child_c = node_r * CHILD_W'(KEYS_PER_NODE + 1) + CHILD_W'(pos_r) + CHILD_W'(1);

  assign sts.walk_ok = found_c && (node_count != '0);
  assign sts.more    = (32'(child_c) < 32'(node_count)) && (32'(child_c) < 32'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (cmd.ld_wr && slot_ok) begin
      mem[row_ext[ROW_W-1:0]][pos_sel[KI_W-1:0]] <= key_r;
    end
    if (cmd.q_read) begin
      row_r <= mem[node_r[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_r   <= in_load_slot;
      key_r    <= in_load_key;
      search_r <= in_search_value;
      result_r <= max_key;
      node_r   <= '0;
    end
    if (cmd.ld_div) begin
      q_est_r <= q_est_nxt;
    end
    if (cmd.q_cmp) begin
      pos_r <= pos_c;
      if (pos_c != POS_W'(KEYS_PER_NODE)) begin
        result_r <= row_r[pos_c[KI_W-1:0]];
      end
    end
    if (cmd.q_next) begin
      node_r <= child_c;
    end
    if (cmd.emit) begin
      out_found_r <= found_c;
      out_key_r   <= found_c ? result_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_bound_key = out_key_r;

endmodule

`default_nettype wire

/* sv/static_btree_lower_bound.sv */
// top level: register port, controller and datapath of the b-tree search
`default_nettype none

// Lower-bound search over a static B-tree of KEYS_PER_NODE keys per node held in
// one on-chip memory whose row is a whole node. A load item (opcode 0) keeps busy
// high through a divide state and a write state and gives no result. A query item
// passes a range check and then walks L tree levels before its out_valid strobe,
// where each level is one node-row memory read, one all-keys compare and one child step.
// At 64 nodes of 16 keys L is at most 3; an out-of-range query ends after the range
// check alone. The result is shown for one cycle only and the receiver cannot hold
// it, but a new item may be started in that same cycle.
// Key slots must be loaded before a query reads them; there is no clearing pass.

module static_btree_lower_bound #(
  parameter int KEYS_PER_NODE = 16,
  parameter int MAX_NODES     = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_opcode,
  input  wire logic [sbt_pkg::SLOT_W-1:0]      in_load_slot,
  input  wire logic signed [sbt_pkg::KEY_W-1:0] in_load_key,
  input  wire logic signed [sbt_pkg::KEY_W-1:0] in_search_value,
  output logic                                 out_valid,
  output logic                                 out_found,
  output logic signed [sbt_pkg::KEY_W-1:0]     out_bound_key,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sbt_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [sbt_pkg::DATA_W-1:0]      pwdata,
  output logic [sbt_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import sbt_pkg::*;

  logic [NCNT_W-1:0]       node_count_r;
  logic signed [KEY_W-1:0] max_key_r;
  logic                    wr_en;
  cmd_t                    cmd;
  sts_t                    sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      max_key_r    <= MAX_KEY_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_NODE_COUNT: node_count_r <= pwdata[NCNT_W-1:0];
        REG_MAX_KEY:    max_key_r    <= pwdata[KEY_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NODE_COUNT: prdata = DATA_W'(node_count_r);
      REG_MAX_KEY:    prdata = DATA_W'(max_key_r);
      default:        prdata = '0;
    endcase
  end

  sbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts)
  );

  sbt_dp #(
    .KEYS_PER_NODE (KEYS_PER_NODE),
    .MAX_NODES     (MAX_NODES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_load_slot    (in_load_slot),
    .in_load_key     (in_load_key),
    .in_search_value (in_search_value),
    .node_count      (node_count_r),
    .max_key         (max_key_r),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_bound_key   (out_bound_key)
  );

endmodule

`default_nettype wire

/* sv/sbt_chk.sv */
// port-level checks of the b-tree search, bound to the top level
`default_nettype none

module sbt_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic                         out_found,
  input wire logic [sbt_pkg::KEY_W-1:0]    out_bound_key
);
  import sbt_pkg::*;

  // every accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only appears once its item is finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // at most one strobe per query item, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // a miss reports a zero key
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_bound_key == '0))
    else $error("not-found result carries a key");

endmodule

bind static_btree_lower_bound sbt_chk u_sbt_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_found     (out_found),
  .out_bound_key (out_bound_key)
);

`default_nettype wire

/* bench/testbench.sv */
// testbench for the static b-tree lower bound search: scoreboard class and stimulus
`timescale 1ns / 1ps

module testbench;
  import sbt_pkg::*;

  localparam int KEYS_PER_NODE = 16;
  localparam int NODES_MAX     = 64;
  localparam int SLOT_TOTAL    = KEYS_PER_NODE * NODES_MAX;
  localparam int STALL_LIMIT   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int DEEP_NODES    = 19;
  localparam int ITEM_TARGET   = 450;

  typedef struct {
    logic                    op;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] value;
  } item_t;

  typedef struct {
    logic                    found;
    logic signed [KEY_W-1:0] bound_key;
  } bound_t;

  class sbt_scoreboard;
    logic signed [KEY_W-1:0] slot_keys [SLOT_TOTAL];
    logic [NCNT_W-1:0]       node_count;
    logic signed [KEY_W-1:0] max_key;
    bound_t                  bounds_due[$];
    int                      errors;
    int                      loads;
    int                      queries;
    int                      misses;

    function new();
      node_count = NODE_COUNT_RST;
      max_key    = MAX_KEY_RST;
      errors     = 0;
      loads      = 0;
      queries    = 0;
      misses     = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_NODE_COUNT: node_count = value[NCNT_W-1:0];
        REG_MAX_KEY:    max_key = value;
        default: ;
      endcase
    endfunction

    function bound_t lower_bound(logic signed [KEY_W-1:0] v);
      bound_t      r;
      int unsigned node;
      int unsigned limit;
      int unsigned pos;
      int unsigned i;
      r.found = (v <= max_key);
      r.bound_key = r.found ? max_key : '0;
      if (!r.found) return r;
      limit = (node_count > NODES_MAX) ? NODES_MAX : node_count;
      node = 0;
      while (node < limit) begin
        pos = KEYS_PER_NODE;
        // scan downward so the first key not below v wins
        for (i = KEYS_PER_NODE; i > 0; i--) begin
          if (slot_keys[node * KEYS_PER_NODE + i - 1] >= v) pos = i - 1;
        end
        if (pos < KEYS_PER_NODE) r.bound_key = slot_keys[node * KEYS_PER_NODE + pos];
        node = node * (KEYS_PER_NODE + 1) + pos + 1;
      end
      return r;
    endfunction

    function void note_item(item_t it);
      bound_t r;
      if (it.op == OP_LOAD) begin
        slot_keys[it.slot] = it.key;
        loads++;
      end else begin
        r = lower_bound(it.value);
        if (!r.found) misses++;
        queries++;
        bounds_due.push_back(r);
      end
    endfunction

    function int pending();
      return bounds_due.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic found, logic signed [KEY_W-1:0] bound_key);
      bound_t e;
      if (bounds_due.size() == 0) begin
        report($sformatf("result found=%0b key=%0d with no query waiting", found, bound_key));
      end else begin
        e = bounds_due.pop_front();
        if (found !== e.found)
          report($sformatf("found %0b, want %0b", found, e.found));
        if (bound_key !== e.bound_key)
          report($sformatf("bound_key %0d, want %0d", bound_key, e.bound_key));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_opcode;
  logic [SLOT_W-1:0]       in_load_slot;
  logic signed [KEY_W-1:0] in_load_key;
  logic signed [KEY_W-1:0] in_search_value;
  logic                    out_valid;
  logic                    out_found;
  logic signed [KEY_W-1:0] out_bound_key;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  sbt_scoreboard sb;

  // tree image built in order, padded with the largest key
  int                      tree_img [SLOT_TOTAL];
  int                      tree_sorted[$];
  int                      tree_nodes;
  int                      fill_pos;
  logic signed [KEY_W-1:0] cur_max;
  int                      burst_left;
  int                      stall_cycles;

  static_btree_lower_bound u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_load_slot    (in_load_slot),
    .in_load_key     (in_load_key),
    .in_search_value (in_search_value),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_bound_key   (out_bound_key),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_found, out_bound_key);
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("timeout: no item or result for %0d cycles", STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic item_t make_load(int slot, logic signed [KEY_W-1:0] key);
    item_t it;
    it.op    = OP_LOAD;
    it.slot  = SLOT_W'(slot);
    it.key   = key;
    it.value = $urandom;
    return it;
  endfunction

  function automatic item_t make_query(logic signed [KEY_W-1:0] value);
    item_t it;
    it.op    = OP_QUERY;
    it.slot  = SLOT_W'($urandom);
    it.key   = $urandom;
    it.value = value;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue(item_t it);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start           <= 1'b1;
    in_opcode       <= it.op;
    in_load_slot    <= it.slot;
    in_load_key     <= it.key;
    in_search_value <= it.value;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // wait until every query has answered, then let a trailing load finish
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // in-order fill: child i, key i, ..., key 15, child 16
  function automatic void lay_out(int unsigned node);
    int unsigned i;
    if (node >= tree_nodes) return;
    for (i = 0; i <= KEYS_PER_NODE; i++) begin
      lay_out(node * (KEYS_PER_NODE + 1) + i + 1);
      if (i < KEYS_PER_NODE) begin
        tree_img[node * KEYS_PER_NODE + i] = (fill_pos < tree_sorted.size()) ?
          tree_sorted[fill_pos] : tree_sorted[tree_sorted.size() - 1];
        fill_pos++;
      end
    end
  endfunction

  task automatic build_tree(int nodes);
    int count;
    int mode;
    int i;
    int base;
    tree_sorted.delete();
    count = ($urandom_range(0, 2) == 0) ? $urandom_range(1, KEYS_PER_NODE * nodes) :
            KEYS_PER_NODE * nodes - $urandom_range(0, 3);
    mode = $urandom_range(0, 2);
    base = $urandom;
    for (i = 0; i < count; i++) begin
      // narrow spread gives duplicates and close neighbors
      if (mode == 0) tree_sorted.push_back($urandom);
      else tree_sorted.push_back(base + $urandom_range(0, 4 * count));
    end
    if (mode == 2) begin
      tree_sorted.push_back(32'sh80000000);
      tree_sorted.push_back(32'sh7fffffff);
    end
    tree_sorted.sort();
    tree_nodes = nodes;
    fill_pos = 0;
    lay_out(0);
    for (i = 0; i < KEYS_PER_NODE * nodes; i++) issue(make_load(i, tree_img[i]));
  endtask

  function automatic logic signed [KEY_W-1:0] pick_value();
    logic signed [KEY_W-1:0] stored;
    stored = tree_sorted[$urandom_range(0, tree_sorted.size() - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return stored;
      4:          return stored + 1;
      5:          return stored - 1;
      6, 7:       return $urandom;
      8:          return $urandom_range(0, 1) ? 32'sh80000000 : 32'sh7fffffff;
      default:    return cur_max + $urandom_range(0, 1);
    endcase
  endfunction

  task automatic run_phase(int node_reg, int build_nodes, int n_items);
    if (build_nodes > 0) build_tree(build_nodes);
    settle();
    write_reg(REG_NODE_COUNT, node_reg);
    cur_max = ($urandom_range(0, 5) == 0) ? $urandom : tree_sorted[tree_sorted.size() - 1];
    write_reg(REG_MAX_KEY, cur_max);
    repeat (n_items) begin
      // stray loads rewrite random slots, whether already filled or not
      if ($urandom_range(0, 7) == 0)
        issue(make_load($urandom_range(0, SLOT_TOTAL - 1), $urandom));
      else
        issue(make_query(pick_value()));
      if ($urandom_range(0, 39) == 0) settle();
    end
    settle();
  endtask

  initial begin
    int i;
    int nodes;
    int node_reg;
    sb = new();
    burst_left = 0;
    stall_cycles = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= OP_LOAD;
    in_load_slot    <= '0;
    in_load_key     <= '0;
    in_search_value <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one node holding both key extremes
    write_reg(REG_NODE_COUNT, 1);
    write_reg(REG_MAX_KEY, 32'sh7fffffff);
    for (i = 0; i < KEYS_PER_NODE; i++) begin
      if (i == 0) issue(make_load(i, 32'sh80000000));
      else if (i == KEYS_PER_NODE - 1) issue(make_load(i, 32'sh7fffffff));
      else issue(make_load(i, i * 1000 - 7000));
    end
    issue(make_load(SLOT_TOTAL - 1, 32'sh5555aaaa));
    issue(make_query(32'sh80000000));
    issue(make_query(32'sh7fffffff));
    issue(make_query(3));
    settle();
    // value past the largest key, and exactly at it
    write_reg(REG_MAX_KEY, 100);
    issue(make_query(101));
    issue(make_query(100));
    settle();
    write_reg(REG_MAX_KEY, 32'sh80000000);
    issue(make_query(32'sh80000000));
    settle();
    // empty tree answers with the largest key
    write_reg(REG_NODE_COUNT, 0);
    write_reg(REG_MAX_KEY, 32'sh7fffffff);
    issue(make_query(5));
    settle();

    // node count beyond storage: walk goes node 0, node 3, then to a child past the last node
    for (i = 0; i < KEYS_PER_NODE; i++) begin
      issue(make_load(3 * KEYS_PER_NODE + i, (i < 12) ? -9000 : -5900 + (i - 12) * 100));
    end
    write_reg(REG_NODE_COUNT, 127);
    issue(make_query(-5650));
    issue(make_query(-5000));
    settle();
    write_reg(REG_NODE_COUNT, NODES_MAX + 1);
    issue(make_query(-5950));
    settle();

    // one tree deep enough for a three-level walk
    run_phase(DEEP_NODES, DEEP_NODES, 40);

    // small trees from here on, node count mostly kept inside the loaded nodes
    while (sb.loads + sb.queries < ITEM_TARGET) begin
      nodes = $urandom_range(1, 3);
      node_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DEEP_NODES) : nodes;
      run_phase(node_reg, nodes, $urandom_range(20, 40));
    end

    settle();
    $display("ran %0d loads and %0d queries, %0d of them above the largest key",
             sb.loads, sb.queries, sb.misses);
    $display("trees of 1 to %0d nodes, node count register from 0 up past the %0d-node limit",
             DEEP_NODES, NODES_MAX);
    if (sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
